### hdl/mpdp_pkg.sv
// shared constants and types for the mixed precision integer dot product
`default_nettype none
package mpdp_pkg;

   localparam int WORD_W  = 32;
   localparam int COUNT_W = 4;
   localparam int MODE_W  = 2;
   localparam int LANE_NUM = 8;
   localparam int A_OP_W = 17;
   localparam int B_OP_W = 16;
   localparam int PROD_W = A_OP_W + B_OP_W;
   localparam int SUM_W  = PROD_W + $clog2(LANE_NUM);
   localparam int ACC_W  = 64;

   localparam logic [MODE_W-1:0] MODE_S16  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_U8S8 = 2'd1;
   localparam logic [MODE_W-1:0] MODE_U4S4 = 2'd2;

   localparam int LANES_S16  = WORD_W / 16;
   localparam int LANES_U8S8 = WORD_W / 8;
   localparam int LANES_U4S4 = WORD_W / 4;

   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   typedef struct packed {
      logic valid;
      logic last;
   } stage_ctl_type;

endpackage
`default_nettype wire

### hdl/mpdp_lane.sv
// one multiply lane: operand unpack by precision mode and a registered product
`default_nettype none
module mpdp_lane #(
   parameter int LANE_IDX = 0
) (
   input  wire logic                           clock,
   input  wire logic                           advance,
   input  wire logic [mpdp_pkg::MODE_W-1:0]    mode,
   input  wire logic [mpdp_pkg::WORD_W-1:0]    a_word,
   input  wire logic [mpdp_pkg::WORD_W-1:0]    b_word,
   input  wire logic [mpdp_pkg::COUNT_W-1:0]   lane_count,
   output mpdp_pkg::prod_type                  prod_ff
);
   import mpdp_pkg::*;

   localparam int Off16 = (LANE_IDX < LANES_S16)  ? LANE_IDX * 16 : 0;
   localparam int Off8  = (LANE_IDX < LANES_U8S8) ? LANE_IDX * 8  : 0;
   localparam int Off4  = (LANE_IDX < LANES_U4S4) ? LANE_IDX * 4  : 0;
   localparam logic [COUNT_W-1:0] IdxC = COUNT_W'(LANE_IDX);

   logic signed [A_OP_W-1:0] a_op;
   logic signed [B_OP_W-1:0] b_op;
   logic                     in_count;
   prod_type                 prod_in;

   assign in_count = (IdxC < lane_count);

   always_comb begin
      a_op = '0;
      b_op = '0;
      case (mode)
         MODE_S16: begin
            if (in_count && (LANE_IDX < LANES_S16)) begin
               a_op = {a_word[Off16 + 15], a_word[Off16 +: 16]};
               b_op = b_word[Off16 +: 16];
            end
         end
         MODE_U8S8: begin
            if (in_count && (LANE_IDX < LANES_U8S8)) begin
               a_op = {{(A_OP_W - 8){1'b0}}, a_word[Off8 +: 8]};
               b_op = {{(B_OP_W - 8){b_word[Off8 + 7]}}, b_word[Off8 +: 8]};
            end
         end
         MODE_U4S4: begin
            if (in_count && (LANE_IDX < LANES_U4S4)) begin
               a_op = {{(A_OP_W - 4){1'b0}}, a_word[Off4 +: 4]};
               b_op = {{(B_OP_W - 4){b_word[Off4 + 3]}}, b_word[Off4 +: 4]};
            end
         end
         default: begin
            a_op = '0;
            b_op = '0;
         end
      endcase
   end

   assign prod_in = a_op * b_op;

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
      end
   end

endmodule
`default_nettype wire

### hdl/mpdp_merge.sv
// merging stage: adds the lane products of one word into a registered partial sum
`default_nettype none
module mpdp_merge (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     advance,
   input  mpdp_pkg::prod_type            prod [mpdp_pkg::LANE_NUM],
   input  mpdp_pkg::stage_ctl_type       ctl_in,
   output mpdp_pkg::sum_type             sum_ff,
   output mpdp_pkg::stage_ctl_type       ctl_ff
);
   import mpdp_pkg::*;

   sum_type sum_in;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < LANE_NUM; i++) begin
         sum_in = sum_in + {{(SUM_W - PROD_W){prod[i][PROD_W-1]}}, prod[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff <= sum_in;
      end
   end

endmodule
`default_nettype wire

### hdl/mixed_precision_int_dot_product.sv
// top level: lanes, merge stage, 64-bit accumulator and result register
// Accepts one transaction per cycle unless req_stall is high. Each transaction
// carries one 32-bit word of each vector; eight multiply lanes decode the word
// per precision_mode (two int16 lanes, four u8 x s8 lanes or eight u4 x s4
// nibbles) and register their products, a merge stage adds them, and the third
// stage adds that into a 64-bit wrapping accumulator. A transaction flagged last
// passes the lane and merge registers, shows its sum on the result channel and
// clears the accumulator. Only a last transaction waits on a stalled result
// register; while it waits, the lane stage behind it takes at most one more
// transaction, then the input stalls. Write precision_mode only while idle.
`default_nettype none
module mixed_precision_int_dot_product (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [mpdp_pkg::WORD_W-1:0]        req_a_word,
   input  wire logic [mpdp_pkg::WORD_W-1:0]        req_b_word,
   input  wire logic [mpdp_pkg::COUNT_W-1:0]       req_lane_count,
   input  wire logic                               req_is_last,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [mpdp_pkg::ACC_W-1:0]       rsp_dot_sum,
   input  wire logic                               csr_write_en,
   input  wire logic [mpdp_pkg::MODE_W-1:0]        csr_write_data
);
   import mpdp_pkg::*;

   logic [MODE_W-1:0]  mode_ff;
   stage_ctl_type      s1_ctl_ff;
   stage_ctl_type      s1_ctl_in;
   stage_ctl_type      s2_ctl;
   prod_type           prod [LANE_NUM];
   sum_type            s2_sum;
   logic [ACC_W-1:0]   acc_ff;
   logic [ACC_W-1:0]   acc_in;
   logic [ACC_W-1:0]   total;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [ACC_W-1:0]   rsp_sum_ff;
   logic               out_free;
   logic               s1_adv;
   logic               s2_adv;
   logic               s2_fire;

   // only a last transaction needs the result register
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_adv    = !s2_ctl.valid || !s2_ctl.last || out_free;
   assign s1_adv    = !s1_ctl_ff.valid || s2_adv;
   assign req_stall = !s1_adv;
   assign s2_fire   = s2_ctl.valid && s2_adv;

   assign s1_ctl_in.valid = req_valid;
   assign s1_ctl_in.last  = req_is_last;

   for (genvar g = 0; g < LANE_NUM; g++) begin : g_lane
      mpdp_lane #(
         .LANE_IDX(g)
      ) u_lane (
         .clock      (clock),
         .advance    (s1_adv),
         .mode       (mode_ff),
         .a_word     (req_a_word),
         .b_word     (req_b_word),
         .lane_count (req_lane_count),
         .prod_ff    (prod[g])
      );
   end

   mpdp_merge u_merge (
      .clock   (clock),
      .reset   (reset),
      .advance (s2_adv),
      .prod    (prod),
      .ctl_in  (s1_ctl_ff),
      .sum_ff  (s2_sum),
      .ctl_ff  (s2_ctl)
   );

   always_comb begin
      total = acc_ff + {{(ACC_W - SUM_W){s2_sum[SUM_W-1]}}, s2_sum};
      acc_in = acc_ff;
      if (s2_fire) begin
         acc_in = s2_ctl.last ? '0 : total;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (s2_fire && s2_ctl.last) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_S16;
         s1_ctl_ff    <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            mode_ff <= csr_write_data;
         end
         if (s1_adv) begin
            s1_ctl_ff <= s1_ctl_in;
         end
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire && s2_ctl.last) begin
         rsp_sum_ff <= total;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_dot_sum = rsp_sum_ff;

endmodule
`default_nettype wire

### test/mixed_precision_int_dot_product_test.sv
// self-checking testbench for the mixed precision integer dot product accumulator
`default_nettype none
module mixed_precision_int_dot_product_test;
   import mpdp_pkg::*;

   localparam int CLK_HALF = 4;
   localparam int RESET_CYCLES = 8;
   localparam int SETTLE_CYCLES = 6;
   localparam int RANDOM_WORDS = 1750;
   localparam int LIMIT_CYCLES = 400000;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [WORD_W-1:0] req_a_word;
   logic [WORD_W-1:0] req_b_word;
   logic [COUNT_W-1:0] req_lane_count;
   logic req_is_last;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [ACC_W-1:0] rsp_dot_sum;
   logic csr_write_en;
   logic [MODE_W-1:0] csr_write_data;

   // predictor state
   logic [MODE_W-1:0] lane_mode;
   logic [ACC_W-1:0] running_sum;
   logic signed [ACC_W-1:0] pending_sums[$];

   // stimulus controls and bookkeeping
   bit sender_gaps_on;
   bit receiver_gaps_on;
   int rsp_hold_len;
   int words_sent;
   int vectors_sent;
   int mode_writes;
   int sums_checked;
   int long_holds;
   int fail_count;

   mixed_precision_int_dot_product dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_a_word(req_a_word),
      .req_b_word(req_b_word),
      .req_lane_count(req_lane_count),
      .req_is_last(req_is_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_dot_sum(rsp_dot_sum),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data)
   );

   initial clock = 1'b0;
   always #(CLK_HALF) clock = ~clock;

   initial begin
      #(2 * CLK_HALF * LIMIT_CYCLES);
      $display("CHECK FAILED");
      $finish;
   end

   // sum of the lane products of one word pair under the given mode
   function automatic longint word_dot(input logic [MODE_W-1:0] mode,
                                       input logic [WORD_W-1:0] a,
                                       input logic [WORD_W-1:0] b,
                                       input logic [COUNT_W-1:0] cnt);
      longint total;
      int n;
      total = 0;
      case (mode)
         MODE_S16: begin
            n = (cnt > LANES_S16) ? LANES_S16 : cnt;
            for (int i = 0; i < n; i++)
               total += longint'($signed(a[i*16 +: 16])) * longint'($signed(b[i*16 +: 16]));
         end
         MODE_U8S8: begin
            n = (cnt > LANES_U8S8) ? LANES_U8S8 : cnt;
            for (int i = 0; i < n; i++)
               total += longint'(a[i*8 +: 8]) * longint'($signed(b[i*8 +: 8]));
         end
         MODE_U4S4: begin
            n = (cnt > LANES_U4S4) ? LANES_U4S4 : cnt;
            for (int i = 0; i < n; i++)
               total += longint'(a[i*4 +: 4]) * longint'($signed(b[i*4 +: 4]));
         end
         default: begin
            // no lanes are valid in the unused mode
            total = 0;
         end
      endcase
      return total;
   endfunction

   function automatic int lanes_of(input logic [MODE_W-1:0] mode);
      case (mode)
         MODE_S16:  return LANES_S16;
         MODE_U8S8: return LANES_U8S8;
         default:   return LANES_U4S4;
      endcase
   endfunction

   // mostly short, a few long
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return $urandom_range(1, 2);
      else if (r < 95)
         return $urandom_range(3, 6);
      else
         return $urandom_range(12, 40);
   endfunction

   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(0, 9))
         0: return 32'hFFFF_FFFF;
         1: return 32'h0000_0000;
         2: return 32'h8000_8000;
         3: return 32'h8888_8888;
         4: return 32'h7F7F_7F7F;
         default: return $urandom;
      endcase
   endfunction

   // track mode writes and accepted transactions
   always @(posedge clock) begin
      if (reset) begin
         lane_mode = MODE_S16;
         running_sum = '0;
      end else begin
         if (csr_write_en)
            lane_mode = csr_write_data;
         if (req_valid && !req_stall) begin
            running_sum = running_sum +
                          ACC_W'(word_dot(lane_mode, req_a_word, req_b_word, req_lane_count));
            if (req_is_last) begin
               pending_sums.push_back($signed(running_sum));
               running_sum = '0;
            end
         end
      end
   end

   always @(posedge clock) begin
      logic signed [ACC_W-1:0] expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_sums.size() == 0) begin
            $error("dot_sum: expected none, actual %0d", rsp_dot_sum);
            fail_count++;
         end else begin
            expected = pending_sums.pop_front();
            if (rsp_dot_sum !== expected) begin
               $error("dot_sum: expected %0d, actual %0d", expected, rsp_dot_sum);
               fail_count++;
            end
         end
         sums_checked++;
      end
   end

   // result side: random stalls plus long hold-offs on request
   initial begin : result_receiver
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_len > 0) begin
            rsp_stall = 1'b1;
            long_holds++;
            repeat (rsp_hold_len) @(negedge clock);
            rsp_hold_len = 0;
            rsp_stall = 1'b0;
         end else if (receiver_gaps_on && $urandom_range(0, 99) < 20) begin
            n = idle_length();
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   task automatic send_word(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                            input logic [COUNT_W-1:0] cnt, input logic last);
      int gap;
      gap = 0;
      if (sender_gaps_on && $urandom_range(0, 99) >= 65)
         gap = idle_length();
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_a_word = a;
      req_b_word = b;
      req_lane_count = cnt;
      req_is_last = last;
      do @(posedge clock); while (req_stall);
      words_sent++;
      if (last)
         vectors_sent++;
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // sender pauses until every sum is back and the pipeline has emptied
   task automatic wait_for_sums();
      stop_sending();
      while (pending_sums.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic [MODE_W-1:0] mode);
      wait_for_sums();
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_write_data = mode;
      @(negedge clock);
      csr_write_en = 1'b0;
      mode_writes++;
   endtask

   task automatic send_vector(input int words, input int lanes);
      logic [COUNT_W-1:0] cnt;
      for (int w = 0; w < words; w++) begin
         if ($urandom_range(0, 99) < 10)
            cnt = COUNT_W'($urandom_range(0, 15));
         else if (w == words - 1)
            cnt = COUNT_W'($urandom_range(1, lanes));
         else
            cnt = COUNT_W'(lanes);
         send_word(random_word(), random_word(), cnt, w == words - 1);
      end
   endtask

   task automatic test_directed_cases();
      sender_gaps_on = 1'b0;
      receiver_gaps_on = 1'b0;
      write_mode(MODE_S16);
      send_word(32'h8000_8000, 32'h8000_8000, 4'd2, 1'b1);
      send_word(32'h7FFF_7FFF, 32'h8000_8000, 4'd15, 1'b1);   // count clamped to two lanes
      send_word(32'hFFFF_FFFF, 32'h1234_5678, 4'd0, 1'b1);    // zero count still emits
      send_word(32'hABCD_7FFF, 32'h5555_7FFF, 4'd1, 1'b0);
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd2, 1'b1);
      write_mode(MODE_U8S8);
      send_word(32'hFFFF_FFFF, 32'h8080_8080, 4'd4, 1'b1);
      send_word(32'hFFFF_FFFF, 32'h7F7F_7F7F, 4'd8, 1'b1);
      send_word(32'h0000_0000, 32'hFFFF_FFFF, 4'd4, 1'b1);
      send_word(32'h12FF_34FF, 32'h8001_8001, 4'd3, 1'b0);
      send_word(32'hFF00_00FF, 32'h7F00_0080, 4'd1, 1'b1);
      write_mode(MODE_U4S4);
      send_word(32'hFFFF_FFFF, 32'h8888_8888, 4'd8, 1'b1);
      send_word(32'hFFFF_FFFF, 32'h7777_7777, 4'd15, 1'b1);
      send_word(32'hA5A5_A5A5, 32'h5A5A_5A5A, 4'd5, 1'b0);
      send_word(32'h5A5A_5A5A, 32'hA5A5_A5A5, 4'd0, 1'b0);
      send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd1, 1'b1);
      write_mode(MODE_UNUSED);
      send_word(32'hFFFF_FFFF, 32'h8000_8000, 4'd8, 1'b0);
      send_word(32'h7FFF_7FFF, 32'h8000_8000, 4'd2, 1'b1);
      write_mode(MODE_S16);
      // negative sum carried across several words
      for (int i = 0; i < 5; i++)
         send_word(32'h8000_8000, 32'h7FFF_7FFF, 4'd2, i == 4);
      wait_for_sums();
   endtask

   task automatic test_random_vectors();
      logic [MODE_W-1:0] mode;
      logic [MODE_W-1:0] first_modes[4];
      int phase;
      int phase_end;
      int r;
      first_modes = '{MODE_U4S4, MODE_S16, MODE_U8S8, MODE_UNUSED};
      phase = 0;
      while (words_sent < RANDOM_WORDS) begin
         if (phase < 4)
            mode = first_modes[phase];
         else if ($urandom_range(0, 19) == 0)
            mode = MODE_UNUSED;
         else
            mode = MODE_W'($urandom_range(0, 2));
         write_mode(mode);
         sender_gaps_on = (phase % 3) != 1;
         receiver_gaps_on = (phase % 4) != 2;
         phase_end = words_sent + $urandom_range(100, 200);
         while (words_sent < phase_end) begin
            r = $urandom_range(0, 99);
            if (r < 70)
               send_vector($urandom_range(1, 4), lanes_of(mode));
            else if (r < 95)
               send_vector($urandom_range(5, 12), lanes_of(mode));
            else
               send_vector($urandom_range(13, 40), lanes_of(mode));
            if ($urandom_range(0, 99) < 3)
               wait_for_sums();
         end
         phase++;
      end
      wait_for_sums();
   endtask

   task automatic test_result_backpressure();
      write_mode(MODE_S16);
      sender_gaps_on = 1'b0;
      receiver_gaps_on = 1'b0;
      // receiver holds off while every transaction closes a vector
      rsp_hold_len = 120;
      for (int i = 0; i < 40; i++)
         send_word(random_word(), random_word(), COUNT_W'($urandom_range(1, 2)), 1'b1);
      receiver_gaps_on = 1'b1;
      wait_for_sums();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_a_word = '0;
      req_b_word = '0;
      req_lane_count = '0;
      req_is_last = 1'b0;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      sender_gaps_on = 1'b0;
      receiver_gaps_on = 1'b0;
      rsp_hold_len = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_result_backpressure();
      test_random_vectors();

      wait_for_sums();
      repeat (10) @(posedge clock);
      $display("covered %0d word pairs in %0d vectors over %0d mode settings",
               words_sent, vectors_sent, mode_writes);
      $display("%0d dot products checked, %0d long result hold-offs", sums_checked, long_holds);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
`default_nettype wire

### filelist.f
hdl/mpdp_pkg.sv
hdl/mpdp_lane.sv
hdl/mpdp_merge.sv
hdl/mixed_precision_int_dot_product.sv
test/mixed_precision_int_dot_product_test.sv
